// ===== hdl/bps_pkg.sv =====
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and constants of the bilinear pixel sampler.
// ----------------------------------------------------------------------------
package bps_pkg;

	localparam int FRAC_BITS = 8;
	localparam int SIZE_W    = 12;
	localparam int WGT_W     = FRAC_BITS + 1;
	localparam int CWT_W     = 2 * FRAC_BITS + 1;
	localparam int CH_W      = 8;
	localparam int NUM_CH    = 4;
	localparam int PIX_W     = CH_W * NUM_CH;
	localparam int CFG_IDX_W = 1;

	localparam logic [WGT_W-1:0]  W_ONE      = WGT_W'(1 << FRAC_BITS);
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);
	localparam int                ROUND_HALF = 128 * 256;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	// Weight pair of one axis: w1 for the left/top, w2 for the right/bottom.
	typedef struct packed {
		logic [WGT_W-1:0] w1;
		logic [WGT_W-1:0] w2;
	} wpair_t;

	// Corner weights; they always sum to 65536.
	typedef struct packed {
		logic [CWT_W-1:0] w11;
		logic [CWT_W-1:0] w21;
		logic [CWT_W-1:0] w12;
		logic [CWT_W-1:0] w22;
	} cwt_t;

endpackage

// ===== hdl/bilinear_pixel_sampler.sv =====
// ----------------------------------------------------------------------------
// bilinear_pixel_sampler
// Bilinear sampler for RGBA8888 pixels with a fixed-point sample position.
// ----------------------------------------------------------------------------
// done rises once an accepted start beat has passed the s1, s2 and s3 stage
// registers and the output register.
// Throughput: one beat per clock; busy is never raised, the pipeline is fully
// stage-registered (axis resolve, corner weight multiply, lane multiply, lane sum).
// Results are presented for one cycle on done; the receiver cannot stall.
// Reset clears the pipeline valid bits and sets both frame sizes to 256.
module bilinear_pixel_sampler import bps_pkg::*; #(
	parameter int INT_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [SIZE_W-1:0]             cfg_data,
	input  logic                          start,
	output logic                          busy,
	input  logic [INT_BITS+FRAC_BITS-1:0] x_pos,
	input  logic [INT_BITS+FRAC_BITS-1:0] y_pos,
	input  logic [PIX_W-1:0]              top_left,
	input  logic [PIX_W-1:0]              top_right,
	input  logic [PIX_W-1:0]              bottom_left,
	input  logic [PIX_W-1:0]              bottom_right,
	output logic                          done,
	output logic [PIX_W-1:0]              blended_pixel,
	output logic [INT_BITS-2:0]           left_col,
	output logic [INT_BITS-2:0]           top_row
);

	localparam int IDX_W = INT_BITS - 1;

	logic [SIZE_W-1:0] frame_width_q, frame_height_q;

	logic             accept;
	logic [IDX_W-1:0] col_c, row_c;
	wpair_t           wx_c, wy_c;

	logic             valid_s1, valid_s2, valid_s3;
	logic [IDX_W-1:0] col_s1, col_s2, col_s3;
	logic [IDX_W-1:0] row_s1, row_s2, row_s3;
	wpair_t           wx_s1, wy_s1;
	logic [PIX_W-1:0] tl_s1, tr_s1, bl_s1, br_s1;
	logic [PIX_W-1:0] tl_s2, tr_s2, bl_s2, br_s2;
	cwt_t             cwt_s2;
	logic [PIX_W-1:0] lane_pix;

	logic             done_q;
	logic [PIX_W-1:0] blended_pixel_q;
	logic [IDX_W-1:0] left_col_q, top_row_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= SIZE_RESET;
			frame_height_q <= SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bps_axis #(.INT_BITS(INT_BITS)) u_axis_x (
		.pos  (x_pos),
		.size (frame_width_q),
		.idx  (col_c),
		.wgt  (wx_c)
	);

	bps_axis #(.INT_BITS(INT_BITS)) u_axis_y (
		.pos  (y_pos),
		.size (frame_height_q),
		.idx  (row_c),
		.wgt  (wy_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done_q   <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		col_s1 <= col_c;
		row_s1 <= row_c;
		wx_s1  <= wx_c;
		wy_s1  <= wy_c;
		tl_s1  <= top_left;
		tr_s1  <= top_right;
		bl_s1  <= bottom_left;
		br_s1  <= bottom_right;

		col_s2     <= col_s1;
		row_s2     <= row_s1;
		tl_s2      <= tl_s1;
		tr_s2      <= tr_s1;
		bl_s2      <= bl_s1;
		br_s2      <= br_s1;
		cwt_s2.w11 <= CWT_W'(wx_s1.w1) * CWT_W'(wy_s1.w1);
		cwt_s2.w21 <= CWT_W'(wx_s1.w2) * CWT_W'(wy_s1.w1);
		cwt_s2.w12 <= CWT_W'(wx_s1.w1) * CWT_W'(wy_s1.w2);
		cwt_s2.w22 <= CWT_W'(wx_s1.w2) * CWT_W'(wy_s1.w2);

		col_s3 <= col_s2;
		row_s3 <= row_s2;

		blended_pixel_q <= lane_pix;
		left_col_q      <= col_s3;
		top_row_q       <= row_s3;
	end

	for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
		bps_lane u_lane (
			.clk  (clk),
			.cwt  (cwt_s2),
			.tl   (tl_s2[ch*CH_W +: CH_W]),
			.tr   (tr_s2[ch*CH_W +: CH_W]),
			.bl   (bl_s2[ch*CH_W +: CH_W]),
			.br   (br_s2[ch*CH_W +: CH_W]),
			.chan (lane_pix[ch*CH_W +: CH_W])
		);
	end

	assign done          = done_q;
	assign blended_pixel = blended_pixel_q;
	assign left_col      = left_col_q;
	assign top_row       = top_row_q;

	// Every result beat traces back to exactly one accepted start beat.
	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4))
		else $error("result beat without a matching start beat");

	a_start_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##4 done)
		else $error("accepted beat produced no result");

	// The weight pair of each axis always sums to one.
	a_wgt_sum: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ((10'(wx_s1.w1) + 10'(wx_s1.w2)) == 10'd256)
			&& ((10'(wy_s1.w1) + 10'(wy_s1.w2)) == 10'd256))
		else $error("axis weights do not sum to one");

endmodule

// ===== hdl/bps_axis.sv =====
// ----------------------------------------------------------------------------
// bps_axis
// Resolves one axis: clamps the position, picks the neighbour index and
// forms the 9-bit weight pair, with the edge clamp at the frame border.
// ----------------------------------------------------------------------------
module bps_axis import bps_pkg::*; #(
	parameter int INT_BITS = 12
) (
	input  logic [INT_BITS+FRAC_BITS-1:0] pos,
	input  logic [SIZE_W-1:0]             size,
	output logic [INT_BITS-2:0]           idx,
	output wpair_t                        wgt
);

	localparam int POS_W = INT_BITS + FRAC_BITS;
	localparam int CMP_W = ((INT_BITS > SIZE_W) ? INT_BITS : SIZE_W) + 1;

	logic                 neg;
	logic [INT_BITS-2:0]  ipart;
	logic [FRAC_BITS-1:0] frac;
	logic [SIZE_W-1:0]    size_eff;
	logic [CMP_W-1:0]     ipart_nxt;
	logic [CMP_W-1:0]     idx_wide;
	logic                 at_edge;

	always_comb begin
		neg      = pos[POS_W-1];
		ipart    = neg ? '0 : pos[POS_W-2:FRAC_BITS];
		frac     = neg ? '0 : pos[FRAC_BITS-1:0];
		size_eff = (size < SIZE_W'(2)) ? SIZE_W'(2) : size;
		ipart_nxt = CMP_W'(ipart) + CMP_W'(1);
		at_edge  = (ipart_nxt >= CMP_W'(size_eff));
		// On the edge the sample sits on the last pixel: left/top is size-2, size taken as at least 2.
		idx_wide = at_edge ? (CMP_W'(size_eff) - CMP_W'(2)) : CMP_W'(ipart);
		idx      = idx_wide[INT_BITS-2:0];
		wgt.w1   = at_edge ? '0 : (W_ONE - WGT_W'(frac));
		wgt.w2   = at_edge ? W_ONE : WGT_W'(frac);
	end

endmodule

// ===== hdl/bps_lane.sv =====
// ----------------------------------------------------------------------------
// bps_lane
// One byte channel: registers the four weighted corner products, then adds
// them with rounding and returns the blended byte.
// ----------------------------------------------------------------------------
module bps_lane import bps_pkg::*; (
	input  logic            clk,
	input  cwt_t            cwt,
	input  logic [CH_W-1:0] tl,
	input  logic [CH_W-1:0] tr,
	input  logic [CH_W-1:0] bl,
	input  logic [CH_W-1:0] br,
	output logic [CH_W-1:0] chan
);

	localparam int PROD_W = CWT_W + CH_W;
	localparam int SUM_W  = PROD_W + 2;

	logic [PROD_W-1:0] p11_s3, p21_s3, p12_s3, p22_s3;
	logic [SUM_W-1:0]  sum;

	always_ff @(posedge clk) begin
		p11_s3 <= PROD_W'(cwt.w11) * PROD_W'(tl);
		p21_s3 <= PROD_W'(cwt.w21) * PROD_W'(tr);
		p12_s3 <= PROD_W'(cwt.w12) * PROD_W'(bl);
		p22_s3 <= PROD_W'(cwt.w22) * PROD_W'(br);
	end

	always_comb begin
		sum  = SUM_W'(p11_s3) + SUM_W'(p21_s3) + SUM_W'(p12_s3) + SUM_W'(p22_s3)
			+ SUM_W'(ROUND_HALF);
		chan = sum[2*FRAC_BITS+CH_W-1:2*FRAC_BITS];
	end

endmodule

// ===== sim/bps_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bps_checker
// Watches the sampler's ports, recomputes each blended pixel and its top-left
// indices on every accepted beat, and compares them with the results in order.
// ----------------------------------------------------------------------------
module bps_checker import bps_pkg::*; #(
	parameter int INT_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [SIZE_W-1:0]             cfg_data,
	input  logic                          start,
	input  logic                          busy,
	input  logic [INT_BITS+FRAC_BITS-1:0] x_pos,
	input  logic [INT_BITS+FRAC_BITS-1:0] y_pos,
	input  logic [PIX_W-1:0]              top_left,
	input  logic [PIX_W-1:0]              top_right,
	input  logic [PIX_W-1:0]              bottom_left,
	input  logic [PIX_W-1:0]              bottom_right,
	input  logic                          done,
	input  logic [PIX_W-1:0]              blended_pixel,
	input  logic [INT_BITS-2:0]           left_col,
	input  logic [INT_BITS-2:0]           top_row,
	output int                            fail_count,
	output int                            pending
);

	localparam int POS_W = INT_BITS + FRAC_BITS;

	typedef struct packed {
		logic [PIX_W-1:0]    pixel;
		logic [INT_BITS-2:0] col;
		logic [INT_BITS-2:0] row;
	} sample_t;

	logic [SIZE_W-1:0] frame_w;
	logic [SIZE_W-1:0] frame_h;
	sample_t           sample_queue[$];
	sample_t           got;
	sample_t           want;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	// One axis: index of the left/top neighbour and its weight pair.
	function automatic void resolve_axis(input logic [POS_W-1:0] pos,
			input logic [SIZE_W-1:0] size, output logic [INT_BITS-2:0] idx,
			output int unsigned w_near, output int unsigned w_far);
		int unsigned span;
		int unsigned ipart;
		int unsigned frac;
		span = (size < 2) ? 2 : size;
		if (pos[POS_W-1]) begin
			ipart = 0;
			frac = 0;
		end else begin
			ipart = pos[POS_W-2:FRAC_BITS];
			frac = pos[FRAC_BITS-1:0];
		end
		// A neighbour past the edge pins the sample onto the last column or row.
		if (ipart + 1 >= span) begin
			idx = (INT_BITS-1)'(span - 2);
			w_near = 0;
			w_far = W_ONE;
		end else begin
			idx = (INT_BITS-1)'(ipart);
			w_near = W_ONE - frac;
			w_far = frac;
		end
	endfunction

	function automatic sample_t blend_sample(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
			input logic [PIX_W-1:0] tl, input logic [PIX_W-1:0] tr,
			input logic [PIX_W-1:0] bl, input logic [PIX_W-1:0] br,
			input logic [SIZE_W-1:0] fw, input logic [SIZE_W-1:0] fh);
		sample_t     s;
		int unsigned wx1, wx2, wy1, wy2;
		logic [31:0] sum;
		resolve_axis(x, fw, s.col, wx1, wx2);
		resolve_axis(y, fh, s.row, wy1, wy2);
		for (int ch = 0; ch < NUM_CH; ch++) begin
			sum = wx1 * wy1 * tl[ch*CH_W +: CH_W] + wx2 * wy1 * tr[ch*CH_W +: CH_W]
				+ wx1 * wy2 * bl[ch*CH_W +: CH_W] + wx2 * wy2 * br[ch*CH_W +: CH_W]
				+ ROUND_HALF;
			s.pixel[ch*CH_W +: CH_W] = sum[23:16];
		end
		return s;
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w = SIZE_RESET;
			frame_h = SIZE_RESET;
			sample_queue.delete();
			pending = 0;
		end else begin
			// Retire before pushing, so a same-edge beat never pairs with itself.
			if (done) begin
				got = '{blended_pixel, left_col, top_row};
				if (sample_queue.size() == 0) begin
					note_failure($sformatf("unexpected result: pixel %h col %0d row %0d",
						got.pixel, got.col, got.row));
				end else begin
					want = sample_queue.pop_front();
					if (want.pixel !== got.pixel || want.col !== got.col || want.row !== got.row)
						note_failure($sformatf(
							"mismatch: expected pixel %h col %0d row %0d, got pixel %h col %0d row %0d",
							want.pixel, want.col, want.row, got.pixel, got.col, got.row));
				end
			end
			if (start && !busy)
				sample_queue.push_back(blend_sample(x_pos, y_pos, top_left, top_right,
					bottom_left, bottom_right, frame_w, frame_h));
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_WIDTH: begin
						frame_w = cfg_data;
					end
					REG_FRAME_HEIGHT: begin
						frame_h = cfg_data;
					end
					default: begin
					end
				endcase
			end
			pending = sample_queue.size();
		end
	end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives sample beats into the bilinear sampler across several frame sizes,
// from the smallest to beyond the nominal range, with random gaps, while the
// checker compares every result against its own blend computation.
// ----------------------------------------------------------------------------
module tb import bps_pkg::*; ();

	localparam int INT_BITS       = 12;
	localparam int POS_W          = INT_BITS + FRAC_BITS;
	localparam int POS_MAX        = (1 << (POS_W - 1)) - 1;
	localparam int NUM_PHASES     = 8;
	localparam int RANDOM_BEATS   = 1100;
	localparam int WATCHDOG_LIMIT = 2000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [SIZE_W-1:0]     cfg_data;
	logic                  start;
	logic                  busy;
	logic [POS_W-1:0]      x_pos;
	logic [POS_W-1:0]      y_pos;
	logic [PIX_W-1:0]      top_left;
	logic [PIX_W-1:0]      top_right;
	logic [PIX_W-1:0]      bottom_left;
	logic [PIX_W-1:0]      bottom_right;
	logic                  done;
	logic [PIX_W-1:0]      blended_pixel;
	logic [INT_BITS-2:0]   left_col;
	logic [INT_BITS-2:0]   top_row;
	int                    fail_count;
	int                    pending;

	int quiet_cycles = 0;
	bit steady = 1'b0;
	int frame_w_now = 256;
	int frame_h_now = 256;
	int phase_w[NUM_PHASES] = '{256, 2, 2048, 0, 4095, 2, 2048, 100};
	int phase_h[NUM_PHASES] = '{256, 2, 2048, 1, 4095, 2048, 3, 37};

	bilinear_pixel_sampler #(.INT_BITS(INT_BITS)) dut (.*);

	bps_checker #(.INT_BITS(INT_BITS)) u_checker (.*);

	always #5 clk = ~clk;

	// Ends the run if nothing moves on either side for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	task automatic send_sample(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
			input logic [PIX_W-1:0] tl, input logic [PIX_W-1:0] tr,
			input logic [PIX_W-1:0] bl, input logic [PIX_W-1:0] br);
		int   gap;
		logic stalled;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		x_pos <= x;
		y_pos <= y;
		top_left <= tl;
		top_right <= tr;
		bottom_left <= bl;
		bottom_right <= br;
		// busy is stable by the falling edge, so it tells whether the beat goes in.
		do begin
			@(negedge clk);
			stalled = busy;
			@(posedge clk);
		end while (stalled);
		if ($urandom_range(0, 24) == 0)
			steady = !steady;
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	task automatic set_frame(input int w, input int h);
		cfg_we <= 1'b1;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data <= SIZE_W'(w);
		@(posedge clk);
		cfg_index <= REG_FRAME_HEIGHT;
		cfg_data <= SIZE_W'(h);
		@(posedge clk);
		cfg_we <= 1'b0;
		frame_w_now = w;
		frame_h_now = h;
	endtask

	function automatic logic [POS_W-1:0] random_pos(input int size);
		int span;
		int lim;
		int v;
		span = (size < 2) ? 2 : size;
		lim = span * 256 - 1;
		if (lim > POS_MAX)
			lim = POS_MAX;
		case ($urandom_range(0, 9))
			0: begin
				v = $urandom;
			end
			1: begin
				v = -int'($urandom_range(1, 4096));
			end
			2, 3: begin
				v = ((span - 2 + $urandom_range(0, 1)) << FRAC_BITS) | $urandom_range(0, 255);
				if (v > POS_MAX)
					v = POS_MAX;
			end
			default: begin
				v = $urandom_range(0, lim);
			end
		endcase
		return POS_W'(v);
	endfunction

	function automatic logic [PIX_W-1:0] random_pixel();
		case ($urandom_range(0, 7))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_FRAME_WIDTH;
		cfg_data = '0;
		start = 1'b0;
		x_pos = '0;
		y_pos = '0;
		top_left = '0;
		top_right = '0;
		bottom_left = '0;
		bottom_right = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats on the reset frame of 256 by 256.
		send_sample('0, '0, 32'h11223344, 32'h55667788, 32'h99aabbcc, 32'hddeeff00);
		send_sample(POS_W'(POS_MAX), POS_W'(POS_MAX), $urandom, $urandom, $urandom, $urandom);
		send_sample({1'b1, {(POS_W-1){1'b0}}}, {1'b1, {(POS_W-1){1'b0}}},
			$urandom, $urandom, $urandom, $urandom);
		send_sample('1, 20'h00180, $urandom, $urandom, $urandom, $urandom);
		send_sample(20'h00080, 20'h00080, 32'h00ff00ff, 32'hff00ff00, 32'h00ff00ff, 32'hff00ff00);
		send_sample(20'h0feff, 20'h0feff, $urandom, $urandom, $urandom, $urandom);
		send_sample(20'h0ff00, 20'h0ff7f, $urandom, $urandom, $urandom, $urandom);
		send_sample(20'h000ff, 20'h00001, $urandom, $urandom, $urandom, $urandom);
		send_sample(20'h03080, 20'h04080, '1, '1, '1, '1);
		send_sample(20'h05040, 20'h060c0, '0, '0, '0, '0);
		send_sample(20'h00001, 20'h00001, '1, '0, '0, '0);
		send_sample(20'h000ff, 20'h000ff, '0, '0, '0, '1);
		send_sample(20'h10000, 20'h7ff00, $urandom, $urandom, $urandom, $urandom);

		phase_w[NUM_PHASES-1] = $urandom_range(2, 2048);
		phase_h[NUM_PHASES-1] = $urandom_range(2, 2048);
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_results();
			set_frame(phase_w[p], phase_h[p]);
			for (int i = 0; i < RANDOM_BEATS / NUM_PHASES; i++)
				send_sample(random_pos(frame_w_now), random_pos(frame_h_now),
					random_pixel(), random_pixel(), random_pixel(), random_pixel());
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/bps_pkg.sv
hdl/bps_axis.sv
hdl/bps_lane.sv
hdl/bilinear_pixel_sampler.sv
sim/bps_checker.sv
sim/tb.sv
